// File: rtl/core/resistive_touch_coordinate_mapper_assert.svh
// Assertion macros for the touch coordinate mapper.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef RESISTIVE_TOUCH_COORDINATE_MAPPER_ASSERT_SVH
`define RESISTIVE_TOUCH_COORDINATE_MAPPER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define RTCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define RTCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rtcm_pkg.sv
// Package for the touch coordinate mapper: field widths, screen sizes,
// register indexes, sample kinds and the beat structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtcm_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned OVERSAMPLE = 8;
  localparam int unsigned AVG_SHIFT  = 3;
  localparam int unsigned H_SIZE     = 320;
  localparam int unsigned V_SIZE     = 240;

  // Mapping arithmetic: sizes and span fit 12 bits, quotient stays below 2^12
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned QUO_W  = 12;
  localparam int unsigned NUM_W  = SIZE_W + QUO_W;
  localparam int unsigned CNT_W  = $clog2(OVERSAMPLE + 1);
  localparam int unsigned ITER_W = $clog2(QUO_W + 1);

  localparam logic [COORD_W-1:0] NO_TOUCH_POS = 16'hffff;

  // Sample kinds
  localparam logic [MODE_W-1:0] MODE_DETECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_X      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_Y      = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX     = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SAMPLE_W-1:0] sample;
  } rtcm_in_t;

  typedef struct packed {
    logic               touched;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
  } rtcm_out_t;

endpackage

`default_nettype wire

// File: rtl/core/resistive_touch_coordinate_mapper.sv
// Top level of the touch coordinate mapper: sample accumulation, calibrated
// mapping through one shared restoring divider, and the result register.
// Depends on rtcm_pkg and resistive_touch_coordinate_mapper_assert.svh.
//
// Usage:
//   Input beats (in_valid/in_stall/in_data) carry a sample kind and a 12-bit
//   ADC conversion. A detect sample at or above the threshold yields a
//   no-touch result in the next cycle. A detect sample below it arms the
//   block, which then sums OVERSAMPLE X samples and OVERSAMPLE Y samples,
//   one per cycle while in_stall is low. Samples whose kind does not fit
//   the current phase are dropped. The last sample of each axis starts the
//   mapping: a setup step (offset, compare, constant multiply) and
//   QUO_W = 12 restoring division steps on the shared divider. After the
//   last X beat in_stall stays high through setup and division; after the
//   last Y beat it stays high through setup, division and the emit state,
//   in which the touch result is loaded. When clamping or a degenerate
//   calibration settles the value in setup, the divider is skipped. The
//   block takes no new sample until the mapping of an axis is done; a full
//   touch measurement is made of 1 + 2*OVERSAMPLE samples. Results sit in
//   one output register. While a result waits under out_stall it holds,
//   and in_stall is held high as well. Reset (rst, synchronous) returns to
//   idle, empties the output register and restores the register defaults.
//   Configuration (cfg_write/cfg_index/cfg_data) must be written only while
//   idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module resistive_touch_coordinate_mapper (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [rtcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rtcm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire rtcm_pkg::rtcm_in_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output rtcm_pkg::rtcm_out_t                     out_data
);

  import rtcm_pkg::*;

  `include "resistive_touch_coordinate_mapper_assert.svh"

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_XCOL = 3'b010,
    PH_YCOL = 3'b100
  } phase_t;

  typedef enum logic [3:0] {
    ST_READY = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_EMIT  = 4'b1000
  } seq_t;

  localparam logic [CNT_W-1:0]  CNT_DONE  = CNT_W'(OVERSAMPLE);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(QUO_W - 1);
  localparam logic [SIZE_W-1:0] H_SIZE_V  = SIZE_W'(H_SIZE);
  localparam logic [SIZE_W-1:0] V_SIZE_V  = SIZE_W'(V_SIZE);

  // Configuration registers
  logic [SAMPLE_W-1:0] detect_level;
  logic [SAMPLE_W-1:0] x_cal_min;
  logic [SAMPLE_W-1:0] x_cal_max;
  logic [SAMPLE_W-1:0] y_cal_min;
  logic [SAMPLE_W-1:0] y_cal_max;

  // Control and datapath registers
  phase_t              phase;
  seq_t                st;
  logic [SUM_W-1:0]    sum_acc;
  logic [CNT_W-1:0]    sample_count;
  logic [SUM_W-1:0]    avg;
  logic [COORD_W-1:0]  held_x;
  logic [COORD_W-1:0]  res_y;
  logic [SIZE_W-1:0]   rem;
  logic [SIZE_W-1:0]   den;
  logic [QUO_W-1:0]    num_lo;
  logic [ITER_W-1:0]   iter;

  logic                in_accept;
  logic                out_free;
  logic [SUM_W-1:0]    sum_next;
  logic [CNT_W-1:0]    count_next;
  logic                axis_done;

  logic [SAMPLE_W-1:0] cal_lo;
  logic [SAMPLE_W-1:0] cal_hi;
  logic [SIZE_W-1:0]   axis_size;
  logic [SUM_W-1:0]    offs;
  logic [SIZE_W-1:0]   span;
  logic [NUM_W-1:0]    num;
  logic                special;
  logic [SIZE_W-1:0]   special_val;

  logic [SIZE_W:0]     trial;
  logic                step_ge;
  logic [SIZE_W-1:0]   rem_next;
  logic [QUO_W-1:0]    num_lo_next;

  // Handshake: the output register must be able to take a result next cycle
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (st != ST_READY) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  // Accumulate one axis sample
  assign sum_next   = sum_acc + SUM_W'(in_data.sample);
  assign count_next = sample_count + CNT_W'(1);
  assign axis_done  = count_next >= CNT_DONE;

  // Setup: select axis calibration and sort out the edge cases
  always_comb begin
    cal_lo    = (phase == PH_XCOL) ? x_cal_min : y_cal_min;
    cal_hi    = (phase == PH_XCOL) ? x_cal_max : y_cal_max;
    axis_size = (phase == PH_XCOL) ? H_SIZE_V : V_SIZE_V;
    offs      = avg - SUM_W'(cal_lo);
    span      = cal_hi - cal_lo;
    num       = NUM_W'(offs[SIZE_W-1:0]) * NUM_W'(axis_size);
    special     = 1'b1;
    special_val = '0;
    if (cal_hi <= cal_lo) begin
      special_val = (avg > SUM_W'(cal_lo)) ? axis_size : '0;
    end else if (avg <= SUM_W'(cal_lo)) begin
      special_val = '0;
    end else if (offs >= SUM_W'(span)) begin
      special_val = axis_size;
    end else begin
      special = 1'b0;
    end
  end

  // One restoring division step
  assign trial       = {rem, num_lo[QUO_W-1]};
  assign step_ge     = trial >= {1'b0, den};
  assign rem_next    = step_ge ? SIZE_W'(trial - {1'b0, den}) : trial[SIZE_W-1:0];
  assign num_lo_next = {num_lo[QUO_W-2:0], step_ge};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_level <= 12'd2048;
      x_cal_min    <= 12'd0;
      x_cal_max    <= 12'd4095;
      y_cal_min    <= 12'd0;
      y_cal_max    <= 12'd4095;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: detect_level <= cfg_data;
        REG_X_MIN:     x_cal_min    <= cfg_data;
        REG_X_MAX:     x_cal_max    <= cfg_data;
        REG_Y_MIN:     y_cal_min    <= cfg_data;
        REG_Y_MAX:     y_cal_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, accumulator and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      st           <= ST_READY;
      sum_acc      <= '0;
      sample_count <= '0;
    end else begin
      unique case (st)
        ST_READY: begin
          if (in_accept) begin
            if (phase == PH_IDLE && in_data.mode == MODE_DETECT &&
                in_data.sample < detect_level) begin
              phase        <= PH_XCOL;
              sum_acc      <= '0;
              sample_count <= '0;
            end else if ((phase == PH_XCOL && in_data.mode == MODE_X) ||
                         (phase == PH_YCOL && in_data.mode == MODE_Y)) begin
              avg <= sum_next >> AVG_SHIFT;
              if (axis_done) begin
                sum_acc      <= '0;
                sample_count <= '0;
                st           <= ST_SETUP;
              end else begin
                sum_acc      <= sum_next;
                sample_count <= count_next;
              end
            end
          end
        end
        ST_SETUP: begin
          rem    <= num[NUM_W-1:QUO_W];
          num_lo <= num[QUO_W-1:0];
          den    <= span;
          iter   <= '0;
          if (special) begin
            if (phase == PH_XCOL) begin
              held_x <= COORD_W'(special_val);
              phase  <= PH_YCOL;
              st     <= ST_READY;
            end else begin
              res_y <= COORD_W'(special_val);
              st    <= ST_EMIT;
            end
          end else begin
            st <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem    <= rem_next;
          num_lo <= num_lo_next;
          iter   <= iter + ITER_W'(1);
          if (iter == ITER_LAST) begin
            if (phase == PH_XCOL) begin
              held_x <= COORD_W'(num_lo_next);
              phase  <= PH_YCOL;
              st     <= ST_READY;
            end else begin
              res_y <= COORD_W'(num_lo_next);
              st    <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            phase <= PH_IDLE;
            st    <= ST_READY;
          end
        end
        default: st <= ST_READY;
      endcase
    end
  end

  // Result register: load a no-touch or touch beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ST_READY && in_accept && phase == PH_IDLE &&
                 in_data.mode == MODE_DETECT && in_data.sample >= detect_level) begin
      out_valid <= 1'b1;
      out_data  <= '{touched: 1'b0, x_pos: NO_TOUCH_POS, y_pos: NO_TOUCH_POS};
    end else if (st == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
      out_data  <= '{touched: 1'b1, x_pos: held_x, y_pos: res_y};
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Checks
  `RTCM_ASSERT_NOW(a_no_touch_pos, out_valid && !out_data.touched,
    out_data.x_pos == NO_TOUCH_POS && out_data.y_pos == NO_TOUCH_POS,
    "no-touch beat with a coordinate")
  `RTCM_ASSERT_NOW(a_touch_in_range, out_valid && out_data.touched,
    out_data.x_pos <= COORD_W'(H_SIZE) && out_data.y_pos <= COORD_W'(V_SIZE),
    "touch coordinate off screen")
  `RTCM_ASSERT_NOW(a_rem_below_den, st == ST_DIV, rem < den,
    "divider remainder not below span")
  `RTCM_ASSERT_NEXT(a_emit_loads, st == ST_EMIT && out_free,
    out_valid && out_data.touched && phase == PH_IDLE,
    "touch result not loaded on emit")

endmodule

`default_nettype wire
